FILE: src/assert_macros.svh
// Assertion macros used by the RTL of the scanline decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: src/pcx_rle_pkg.sv
// Package with the constants and register indexes of the PCX scanline decoder.
package pcx_rle_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned PLANE_W    = 2;
  localparam int unsigned COUNT_W    = 6;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned OUT_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THREE_PLANES = 2'd3;

  localparam logic [PIX_W-1:0]   RUN_MARK       = 8'hC0;
  localparam logic [COUNT_W-1:0] RUN_COUNT_MASK = 6'h3F;

  typedef struct packed {
    logic [POS_W-1:0]   column;
    logic [POS_W-1:0]   row;
    logic [PLANE_W-1:0] channel;
    logic [PIX_W-1:0]   pixel_value;
  } sample_t;

endpackage

FILE: src/pcx_rle_scanline_decoder.sv
// Top level of the PCX run-length scanline decoder for 8-bit one- or three-plane images.
//
// Usage: coded image bytes enter on the slave stream (s_axis_*), one item per byte.
// Decoded pixels leave on the master stream (m_axis_*), one item per visible sample,
// carrying column, row, plane and value; tlast marks the final pixel caused by a byte.
// User sets the image geometry via the write port (cfg_*) only while idle; not enforced.
//
// Sequence: a run header only loads the pending count. A literal or a run data byte is
// taken, then one shared position unit (incrementer and wrap compares over column, plane
// and row) steps once per sample; once the count runs out, a flush step sends any held
// sample out marked last. The input is not ready from a literal or data byte until that
// flush is done. Each visible sample waits in the held register until the next visible
// sample or the flush shows whether it is last, and then passes to the output stage.
//
// Stalls: a registered output stage holds one pixel; while the receiver stalls and that
// stage is full, the sequencer waits on the next visible sample and nothing is lost.
// Reset: the position, run state and image-done flag clear, the registers return to
// width, line length and height of one with a single plane, and both streams go idle.
// After the last row every further byte is accepted and ignored until reset.
module pcx_rle_scanline_decoder
  import pcx_rle_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port.
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Coded byte input.
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [PIX_W-1:0]      s_axis_tdata_i,  // [7:0] code_byte
  // Decoded pixel output.
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,  // [15:0] column, [31:16] row,
                                                 // [33:32] channel, [41:34] pixel_value,
                                                 // [47:42] zero
  output logic                  m_axis_tlast_o   // last
);

  `include "assert_macros.svh"

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH
  } state_e;

  // Configuration registers.
  logic [POS_W-1:0] width_q, length_q, height_q;
  logic             three_q;

  // Sequencer and position state.
  state_e             state_q, state_d;
  logic [POS_W-1:0]   col_q, col_d;
  logic [POS_W-1:0]   row_q, row_d;
  logic [PLANE_W-1:0] plane_q, plane_d;
  logic               await_q, await_d;
  logic [COUNT_W-1:0] pend_q, pend_d;
  logic               done_q, done_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic [PIX_W-1:0]   val_q, val_d;

  // Held-back sample and output stage.
  sample_t held_q, held_d;
  logic    held_v_q, held_v_d;
  sample_t out_q, out_d;
  logic    out_v_q, out_v_d;
  logic    out_last_q, out_last_d;

  // Shared position unit.
  logic [POS_W:0]     len_x, hgt_x;
  logic [PLANE_W:0]   planes_x;
  logic               col_wrap, plane_wrap, row_wrap;
  logic               visible, out_free, in_acc, step;
  sample_t            cur;

  assign len_x    = (length_q == '0) ? {1'b1, {POS_W{1'b0}}} : {1'b0, length_q};
  assign hgt_x    = (height_q == '0) ? {1'b1, {POS_W{1'b0}}} : {1'b0, height_q};
  assign planes_x = three_q ? 3'd3 : 3'd1;

  assign col_wrap   = ({1'b0, col_q} + 1'b1) >= len_x;
  assign plane_wrap = ({1'b0, plane_q} + 1'b1) >= planes_x;
  assign row_wrap   = ({1'b0, row_q} + 1'b1) >= hgt_x;
  assign visible    = col_q < width_q;

  assign cur = '{column: col_q, row: row_q, channel: plane_q, pixel_value: val_q};

  assign out_free        = !out_v_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // A sample may step unless it is visible and would need to push the held one out
  // into a full output stage.
  assign step = (state_q == ST_RUN) && !done_q && (cnt_q != '0)
             && !(visible && held_v_q && !out_free);

  always_comb begin
    state_d    = state_q;
    col_d      = col_q;
    row_d      = row_q;
    plane_d    = plane_q;
    await_d    = await_q;
    pend_d     = pend_q;
    done_d     = done_q;
    cnt_d      = cnt_q;
    val_d      = val_q;
    held_d     = held_q;
    held_v_d   = held_v_q;
    out_d      = out_q;
    out_last_d = out_last_q;
    out_v_d    = out_v_q && !m_axis_tready_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && !done_q) begin
          val_d = s_axis_tdata_i;
          priority if (await_q) begin
            await_d = 1'b0;
            cnt_d   = pend_q;
            pend_d  = '0;
            state_d = ST_RUN;
          end else if ((s_axis_tdata_i & RUN_MARK) == RUN_MARK) begin
            pend_d  = s_axis_tdata_i[COUNT_W-1:0] & RUN_COUNT_MASK;
            await_d = 1'b1;
          end else begin
            cnt_d   = COUNT_W'(1);
            state_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (done_q || cnt_q == '0) begin
          state_d = ST_FLUSH;
        end else if (step) begin
          if (visible) begin
            if (held_v_q) begin
              out_d      = held_q;
              out_last_d = 1'b0;
              out_v_d    = 1'b1;
            end
            held_d   = cur;
            held_v_d = 1'b1;
          end
          cnt_d = cnt_q - 1'b1;
          if (col_wrap) begin
            col_d = '0;
            if (plane_wrap) begin
              plane_d = '0;
              if (row_wrap) begin
                row_d  = '0;
                done_d = 1'b1;
              end else begin
                row_d = row_q + 1'b1;
              end
            end else begin
              plane_d = plane_q + 1'b1;
            end
          end else begin
            col_d = col_q + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (!held_v_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_d      = held_q;
          out_last_d = 1'b1;
          out_v_d    = 1'b1;
          held_v_d   = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      col_q    <= '0;
      row_q    <= '0;
      plane_q  <= '0;
      await_q  <= 1'b0;
      pend_q   <= '0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
      held_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      width_q  <= POS_W'(1);
      length_q <= POS_W'(1);
      height_q <= POS_W'(1);
      three_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      col_q    <= col_d;
      row_q    <= row_d;
      plane_q  <= plane_d;
      await_q  <= await_d;
      pend_q   <= pend_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
      held_v_q <= held_v_d;
      out_v_q  <= out_v_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
          REG_LINE_LENGTH:  length_q <= cfg_data_i;
          REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
          REG_THREE_PLANES: three_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    val_q      <= val_d;
    held_q     <= held_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_W - 2*POS_W - PLANE_W - PIX_W){1'b0}},
                            out_q.pixel_value, out_q.channel, out_q.row, out_q.column};

  // The input is only taken once the previous byte has flushed its held sample.
  `ASSERT_IMPL(a_ready_no_held, s_axis_tready_o, !held_v_q)
  // An exhausted run always moves on to the flush step.
  `ASSERT_NEXT(a_run_ends, (state_q == ST_RUN) && (cnt_q == '0), state_q == ST_FLUSH)
  // A stalled full output stage is never overwritten by a step.
  `ASSERT_IMPL(a_no_overrun, step && visible && held_v_q, out_free)

endmodule
